### sv/scms_pkg.sv
// Package for the sphere collision motion step unit.
// Types, opcodes, outcome codes, state machine and table geometry; no dependencies.
package scms_pkg;

    localparam int BODY_SPHERES     = 16;
    localparam int OBSTACLE_SPHERES = 256;
    localparam int BODY_AW          = $clog2(BODY_SPHERES);
    localparam int OBST_AW          = $clog2(OBSTACLE_SPHERES);
    localparam int ENTRY_W          = 3 * 32 + 31;
    localparam int CFG_W            = 24;
    localparam logic signed [31:0] GAME_OVER_Y = 32'sd65536;

    typedef enum logic [1:0] {
        OP_LOAD_BODY = 2'd0,
        OP_LOAD_OBST = 2'd1,
        OP_STEP      = 2'd2,
        OP_SET_POS   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        OUT_FREE     = 2'd0,
        OUT_VERTICAL = 2'd1,
        OUT_BLOCKED  = 2'd2,
        OUT_NO_STEP  = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        CFG_BODY_COUNT = 2'd0,
        CFG_OBST_COUNT = 2'd1,
        CFG_TIME_MULT  = 2'd2,
        CFG_NONE       = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_MUL,
        ST_ADD,
        ST_SW_INIT,
        ST_SWEEP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } pair_stat_t;

endpackage

### sv/scms_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module scms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### sv/scms_pair.sv
// Three-stage sphere pair contact test: distance, squares, sum and compare.
// Depends on scms_pkg.
module scms_pair
    import scms_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic [ENTRY_W-1:0]       body_word,
    input  logic [ENTRY_W-1:0]       obst_word,
    input  logic signed [31:0]       tgt_x,
    input  logic signed [31:0]       tgt_y,
    input  logic signed [31:0]       tgt_z,
    output pair_stat_t               stat
);
    logic signed [31:0] tgt [3];
    logic [33:0] d_next [3];
    logic [33:0] d_reg [3];
    logic [31:0] rs_reg, rs_next;
    logic [63:0] sq_reg [3];
    logic [63:0] lim_reg;
    logic        far_reg;
    logic        v1_reg, v2_reg, hit_reg;
    logic [65:0] sum;

    assign tgt[0] = tgt_x;
    assign tgt[1] = tgt_y;
    assign tgt[2] = tgt_z;

    always_comb begin
        logic signed [32:0] c;
        logic signed [33:0] df;
        for (int k = 0; k < 3; k++) begin
            c  = 33'(signed'(body_word[ENTRY_W-1-32*k -: 32])) + 33'(tgt[k]);
            df = 34'(c) - 34'(signed'(obst_word[ENTRY_W-1-32*k -: 32]));
            d_next[k] = df[33] ? 34'(-df) : 34'(df);
        end
        rs_next = 32'(body_word[30:0]) + 32'(obst_word[30:0]);
    end

    assign sum = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);

    always_ff @(posedge aclk) begin
        d_reg   <= d_next;
        rs_reg  <= rs_next;
        far_reg <= (d_reg[0] > 34'(rs_reg)) || (d_reg[1] > 34'(rs_reg))
                   || (d_reg[2] > 34'(rs_reg));
        for (int k = 0; k < 3; k++) begin
            sq_reg[k] <= 64'(d_reg[k][31:0]) * 64'(d_reg[k][31:0]);
        end
        lim_reg <= 64'(rs_reg) * 64'(rs_reg);
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            hit_reg <= v2_reg && !far_reg && (sum <= 66'(lim_reg));
        end
    end

    assign stat.busy = v1_reg | v2_reg;
    assign stat.hit  = hit_reg;
endmodule

### sv/sphere_collision_motion_step_unit.sv
// Top level: body motion step with sphere-set collision against obstacles.
// Depends on scms_pkg, scms_ram, scms_pair.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | opcode, entry_index, vec_xyz, radius, dt
//   m_      | out | m_valid / m_ready  | pos_xyz, move_outcome, game_over
//   cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wr_data
//
// Loads and set position: result in the cycle after acceptance.
// Step: integration in a scale state, then multiply and add states for each axis
// (one multiplier reused per axis), then one or two sweeps of a setup state plus
// a pass over all sphere pairs, one pair read from the tables per cycle, then a
// final state posts the word once the output is free. No clearing pass after reset.
// Input is taken only when idle and the result register is free or being taken.
module sphere_collision_motion_step_unit
    import scms_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [7:0]         s_entry_index,
    input  logic signed [31:0] s_vec_x,
    input  logic signed [31:0] s_vec_y,
    input  logic signed [31:0] s_vec_z,
    input  logic [30:0]        s_sphere_radius,
    input  logic [15:0]        s_delta_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic [1:0]         m_move_outcome,
    output logic               m_game_over,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_wr_data
);
    state_t state_reg, state_next;

    logic [4:0]  body_count_reg;
    logic [8:0]  obst_count_reg;
    logic [23:0] tmul_reg;

    logic signed [31:0] pos_reg [3], pos_next [3];
    logic signed [31:0] vel_reg [3], vel_next [3];
    logic signed [31:0] tgt_reg [3], tgt_next [3];
    logic signed [31:0] acc_reg [3], acc_next [3];
    logic [15:0] dt_reg, dt_next;
    logic [23:0] scale_reg, scale_next;
    logic signed [56:0] prod_reg, prod_next;
    logic [1:0]  ax_reg, ax_next;
    logic        phase_reg, phase_next;
    logic        pass_reg, pass_next;

    logic              issue_reg, issue_next;
    logic [BODY_AW-1:0] bi_reg, bi_next;
    logic [OBST_AW-1:0] oj_reg, oj_next;
    logic              v1_reg, v1_next;
    logic              hit_reg, hit_next;

    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_pos_reg [3], m_pos_next [3];
    logic [1:0]         m_outcome_reg, m_outcome_next;

    logic out_free, accept, sweep_done, last_pair;
    logic [4:0] nb;
    logic [8:0] no;
    logic [ENTRY_W-1:0] wdata, body_word, obst_word;
    logic body_we, obst_we;
    pair_stat_t pst;

    logic signed [31:0] mul_a;
    logic signed [41:0] add_sum;
    logic signed [31:0] add_sat, add_base;
    logic [39:0] scale_full;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign nb = (body_count_reg > 5'(BODY_SPHERES)) ? 5'(BODY_SPHERES) : body_count_reg;
    assign no = (obst_count_reg > 9'(OBSTACLE_SPHERES)) ? 9'(OBSTACLE_SPHERES)
                                                        : obst_count_reg;

    assign wdata   = {s_vec_x, s_vec_y, s_vec_z, s_sphere_radius};
    assign body_we = accept && (s_opcode == OP_LOAD_BODY)
                     && (s_entry_index < 8'(BODY_SPHERES));
    assign obst_we = accept && (s_opcode == OP_LOAD_OBST)
                     && (9'(s_entry_index) < 9'(OBSTACLE_SPHERES));

    scms_ram #(.WIDTH(ENTRY_W), .DEPTH(BODY_SPHERES)) u_body_ram (
        .aclk(aclk), .we(body_we), .waddr(s_entry_index[BODY_AW-1:0]), .wdata(wdata),
        .raddr(bi_reg), .rdata(body_word)
    );

    scms_ram #(.WIDTH(ENTRY_W), .DEPTH(OBSTACLE_SPHERES)) u_obst_ram (
        .aclk(aclk), .we(obst_we), .waddr(s_entry_index[OBST_AW-1:0]), .wdata(wdata),
        .raddr(oj_reg), .rdata(obst_word)
    );

    scms_pair u_pair (
        .aclk(aclk), .aresetn(aresetn), .in_valid(v1_reg),
        .body_word(body_word), .obst_word(obst_word),
        .tgt_x(tgt_reg[0]), .tgt_y(tgt_reg[1]), .tgt_z(tgt_reg[2]),
        .stat(pst)
    );

    assign sweep_done = !issue_reg && !v1_reg && !pst.busy && !pst.hit;
    assign last_pair  = ({1'b0, oj_reg} == 9'(no - 9'd1))
                        && ({1'b0, bi_reg} == 5'(nb - 5'd1));

    assign scale_full = 40'(dt_reg) * 40'(tmul_reg);
    assign mul_a      = phase_reg ? vel_reg[ax_reg] : acc_reg[ax_reg];
    assign add_base   = phase_reg ? pos_reg[ax_reg] : vel_reg[ax_reg];
    assign add_sum    = 42'(add_base) + 42'(signed'(prod_reg[56:16]));
    assign add_sat    = (add_sum[41:31] == {11{add_sum[41]}}) ? add_sum[31:0]
                      : (add_sum[41] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_opcode == OP_STEP) state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD: begin
                if (ax_reg == 2'd2 && phase_reg) state_next = ST_SW_INIT;
                else                             state_next = ST_MUL;
            end
            ST_SW_INIT: state_next = ST_SWEEP;
            ST_SWEEP: begin
                if (sweep_done) begin
                    if (hit_reg && !pass_reg) state_next = ST_SW_INIT;
                    else                      state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        tgt_next       = tgt_reg;
        acc_next       = acc_reg;
        dt_next        = dt_reg;
        scale_next     = scale_reg;
        prod_next      = prod_reg;
        ax_next        = ax_reg;
        phase_next     = phase_reg;
        pass_next      = pass_reg;
        issue_next     = issue_reg;
        bi_next        = bi_reg;
        oj_next        = oj_reg;
        v1_next        = 1'b0;
        hit_next       = hit_reg | pst.hit;
        m_valid_next   = m_valid_reg && !m_ready;
        m_pos_next     = m_pos_reg;
        m_outcome_next = m_outcome_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_opcode)
                        OP_STEP: begin
                            acc_next = '{s_vec_x, s_vec_y, s_vec_z};
                            dt_next  = s_delta_time;
                        end
                        OP_SET_POS: begin
                            pos_next     = '{s_vec_x, s_vec_y, s_vec_z};
                            vel_next     = '{32'sd0, 32'sd0, 32'sd0};
                            m_valid_next = 1'b1;
                            m_pos_next   = '{s_vec_x, s_vec_y, s_vec_z};
                            m_outcome_next = OUT_NO_STEP;
                        end
                        default: begin
                            m_valid_next   = 1'b1;
                            m_pos_next     = pos_reg;
                            m_outcome_next = OUT_NO_STEP;
                        end
                    endcase
                end
            end
            ST_SCALE: begin
                scale_next = scale_full[39:16];
                ax_next    = 2'd0;
                phase_next = 1'b0;
                pass_next  = 1'b0;
            end
            ST_MUL: prod_next = 57'(mul_a) * 57'(signed'({1'b0, scale_reg}));
            ST_ADD: begin
                if (phase_reg) tgt_next[ax_reg] = add_sat;
                else           vel_next[ax_reg] = add_sat;
                if (ax_reg == 2'd2) begin
                    ax_next    = 2'd0;
                    phase_next = 1'b1;
                end else begin
                    ax_next = ax_reg + 2'd1;
                end
            end
            ST_SW_INIT: begin
                issue_next = (nb != 5'd0) && (no != 9'd0);
                bi_next    = '0;
                oj_next    = '0;
                hit_next   = 1'b0;
            end
            ST_SWEEP: begin
                if (issue_reg) begin
                    v1_next = 1'b1;
                    if (last_pair) begin
                        issue_next = 1'b0;
                    end else if ({1'b0, oj_reg} == 9'(no - 9'd1)) begin
                        oj_next = '0;
                        bi_next = bi_reg + 1'b1;
                    end else begin
                        oj_next = oj_reg + 1'b1;
                    end
                end
                if (sweep_done) begin
                    if (!hit_reg) begin
                        pos_next       = tgt_reg;
                        m_outcome_next = pass_reg ? OUT_VERTICAL : OUT_FREE;
                    end else if (!pass_reg) begin
                        pass_next   = 1'b1;
                        tgt_next[0] = pos_reg[0];
                        tgt_next[2] = pos_reg[2];
                    end else begin
                        vel_next       = '{32'sd0, 32'sd0, 32'sd0};
                        m_outcome_next = OUT_BLOCKED;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_pos_next   = pos_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        tgt_reg       <= tgt_next;
        acc_reg       <= acc_next;
        dt_reg        <= dt_next;
        scale_reg     <= scale_next;
        prod_reg      <= prod_next;
        m_pos_reg     <= m_pos_next;
        m_outcome_reg <= m_outcome_next;
        bi_reg        <= bi_next;
        oj_reg        <= oj_next;
        ax_reg        <= ax_next;
        phase_reg     <= phase_next;
        pass_reg      <= pass_next;
        hit_reg       <= hit_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '{32'sd0, 32'sd0, 32'sd0};
            vel_reg        <= '{32'sd0, 32'sd0, 32'sd0};
            issue_reg      <= 1'b0;
            v1_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
            body_count_reg <= 5'd1;
            obst_count_reg <= 9'd0;
            tmul_reg       <= 24'd65536;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            vel_reg     <= vel_next;
            issue_reg   <= issue_next;
            v1_reg      <= v1_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_BODY_COUNT: body_count_reg <= cfg_wr_data[4:0];
                    CFG_OBST_COUNT: obst_count_reg <= cfg_wr_data[8:0];
                    CFG_TIME_MULT:  tmul_reg       <= cfg_wr_data[23:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pos_x        = m_pos_reg[0];
    assign m_pos_y        = m_pos_reg[1];
    assign m_pos_z        = m_pos_reg[2];
    assign m_move_outcome = m_outcome_reg;
    assign m_game_over    = m_pos_reg[1] < GAME_OVER_Y;
endmodule

### bench/tb.sv
// Self-checking bench for sphere_collision_motion_step_unit.
// Predicts each result word in step with the input stream; depends on scms_pkg.
`timescale 1ns / 100ps
module tb;
    import scms_pkg::*;

    typedef struct {
        op_t               op;
        logic [7:0]        idx;
        logic signed [31:0] x, y, z;
        logic [30:0]       rad;
        logic [15:0]       dt;
    } cmd_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        outcome_t          oc;
        logic              go;
    } res_t;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready;
    logic [1:0] s_opcode = '0;
    logic [7:0] s_entry_index = '0;
    logic signed [31:0] s_vec_x = '0, s_vec_y = '0, s_vec_z = '0;
    logic [30:0] s_sphere_radius = '0;
    logic [15:0] s_delta_time = '0;
    logic m_valid, m_ready = 0;
    logic signed [31:0] m_pos_x, m_pos_y, m_pos_z;
    logic [1:0] m_move_outcome;
    logic m_game_over;
    logic cfg_wr_en = 0;
    logic [1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    sphere_collision_motion_step_unit dut (.*);

    // predictor state
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic signed [31:0] bcen [BODY_SPHERES][3];
    logic [30:0]        brad [BODY_SPHERES];
    logic signed [31:0] ocen [OBSTACLE_SPHERES][3];
    logic [30:0]        orad [OBSTACLE_SPHERES];
    logic [4:0]  body_cnt;
    logic [8:0]  obst_cnt;
    logic [23:0] tmult;

    res_t expected_pos[$];
    int errors = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int cyc = 0;

    initial forever #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc % 97 == 0) stall_mode <= $urandom_range(0, 2);
        m_ready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic bit body_hits(input logic signed [31:0] at [3]);
        int nb, no;
        logic [32:0] rs;
        logic [127:0] lim, sum, d;
        longint dl;
        nb = body_cnt > BODY_SPHERES ? BODY_SPHERES : body_cnt;
        no = obst_cnt > OBSTACLE_SPHERES ? OBSTACLE_SPHERES : obst_cnt;
        for (int i = 0; i < nb; i++)
            for (int j = 0; j < no; j++) begin
                rs = {2'b0, brad[i]} + {2'b0, orad[j]};
                lim = 128'(rs) * 128'(rs);
                sum = '0;
                for (int k = 0; k < 3; k++) begin
                    dl = longint'(bcen[i][k]) + longint'(at[k]) - longint'(ocen[j][k]);
                    if (dl < 0) dl = -dl;
                    d = 128'(dl);
                    sum += d * d;
                end
                if (sum <= lim) return 1;
            end
        return 0;
    endfunction

    function automatic res_t predict_motion(cmd_t c);
        res_t r;
        longint s;
        logic signed [31:0] acc [3];
        logic signed [31:0] tgt [3];
        r.oc = OUT_NO_STEP;
        acc = '{c.x, c.y, c.z};
        case (c.op)
            OP_LOAD_BODY: if (c.idx < BODY_SPHERES) begin
                bcen[c.idx] = acc;
                brad[c.idx] = c.rad;
            end
            OP_LOAD_OBST: if (c.idx < OBSTACLE_SPHERES) begin
                ocen[c.idx] = acc;
                orad[c.idx] = c.rad;
            end
            OP_STEP: begin
                s = (longint'(c.dt) * longint'(tmult)) >> 16;
                for (int k = 0; k < 3; k++)
                    vel[k] = sat32(longint'(vel[k]) + ((longint'(acc[k]) * s) >>> 16));
                for (int k = 0; k < 3; k++)
                    tgt[k] = sat32(longint'(pos[k]) + ((longint'(vel[k]) * s) >>> 16));
                if (!body_hits(tgt)) begin
                    pos = tgt;
                    r.oc = OUT_FREE;
                end else begin
                    tgt[0] = pos[0];
                    tgt[2] = pos[2];
                    if (!body_hits(tgt)) begin
                        pos = tgt;
                        r.oc = OUT_VERTICAL;
                    end else begin
                        vel = '{0, 0, 0};
                        r.oc = OUT_BLOCKED;
                    end
                end
            end
            default: begin
                pos = acc;
                vel = '{0, 0, 0};
            end
        endcase
        r.x = pos[0];
        r.y = pos[1];
        r.z = pos[2];
        r.go = pos[1] < GAME_OVER_Y;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%t %s: got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pos.size() == 0) begin
                report("unexpected word", m_pos_x, 0);
            end else begin
                res_t e;
                e = expected_pos.pop_front();
                if (m_pos_x !== e.x) report("pos_x", m_pos_x, e.x);
                if (m_pos_y !== e.y) report("pos_y", m_pos_y, e.y);
                if (m_pos_z !== e.z) report("pos_z", m_pos_z, e.z);
                if (m_move_outcome !== e.oc) report("move_outcome", m_move_outcome, e.oc);
                if (m_game_over !== e.go) report("game_over", m_game_over, e.go);
            end
        end
    end

    // called at a rising edge; returns at the edge the word is taken
    task automatic send_word(cmd_t c);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_opcode <= c.op;
        s_entry_index <= c.idx;
        s_vec_x <= c.x;
        s_vec_y <= c.y;
        s_vec_z <= c.z;
        s_sphere_radius <= c.rad;
        s_delta_time <= c.dt;
        do @(posedge aclk); while (!s_ready);
        expected_pos.push_back(predict_motion(c));
        burst_left--;
    endtask

    task automatic drain;
        s_valid <= 0;
        burst_left = 0;
        while (expected_pos.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t r, logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= r;
        cfg_wr_data <= v;
        case (r)
            CFG_BODY_COUNT: body_cnt = v[4:0];
            CFG_OBST_COUNT: obst_cnt = v[8:0];
            CFG_TIME_MULT:  tmult = v[23:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    function automatic cmd_t mk(op_t op, int idx, int x, int y, int z, int rad, int dt);
        cmd_t c;
        c.op = op;
        c.idx = idx[7:0];
        c.x = x;
        c.y = y;
        c.z = z;
        c.rad = rad[30:0];
        c.dt = dt[15:0];
        return c;
    endfunction

    function automatic int rnd_q(int lim);
        return $signed($urandom_range(0, 2 * (lim << 16))) - (lim << 16);
    endfunction

    localparam int ONE = 65536;

    task automatic test_loads;
        for (int i = 0; i < BODY_SPHERES; i++)
            send_word(mk(OP_LOAD_BODY, i, rnd_q(1), rnd_q(1), rnd_q(1), ONE / 2, 0));
        send_word(mk(OP_LOAD_BODY, 255, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 16'hffff));
        send_word(mk(OP_LOAD_BODY, 0, 0, 0, 0, ONE, 0));
        for (int j = 0; j < 8; j++)
            send_word(mk(OP_LOAD_OBST, j, (100 + j) * ONE, 100 * ONE, 0, ONE, 0));
        drain();
    endtask

    task automatic test_extremes;
        send_word(mk(OP_SET_POS, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0));
        send_word(mk(OP_STEP, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 16'hffff));
        send_word(mk(OP_STEP, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 16'hffff));
        drain();
        write_reg(CFG_TIME_MULT, 24'hffffff);
        send_word(mk(OP_SET_POS, 0, 0, ONE, 0, 0, 0));
        send_word(mk(OP_STEP, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 16'hffff));
        send_word(mk(OP_STEP, 0, 0, -ONE, 0, 0, 0));
        drain();
        write_reg(CFG_TIME_MULT, 0);
        send_word(mk(OP_STEP, 0, ONE, ONE, ONE, 0, 16'hffff));
        send_word(mk(OP_SET_POS, 0, 0, ONE - 1, 0, 0, 0));
        drain();
        write_reg(CFG_TIME_MULT, ONE);
    endtask

    task automatic test_collision;
        write_reg(CFG_BODY_COUNT, 1);
        write_reg(CFG_OBST_COUNT, 1);
        send_word(mk(OP_LOAD_OBST, 0, 4 * ONE, 5 * ONE, 0, ONE, 0));
        send_word(mk(OP_SET_POS, 0, ONE + ONE / 2, 5 * ONE, 0, 0, 0));
        send_word(mk(OP_STEP, 0, 4 * ONE, 0, 0, 0, 0));
        send_word(mk(OP_STEP, 0, 4 * ONE, ONE, 0, 0, ONE / 2));
        send_word(mk(OP_SET_POS, 0, 4 * ONE, 5 * ONE, 0, 0, 0));
        send_word(mk(OP_STEP, 0, ONE, ONE, ONE, 0, ONE / 4));
        send_word(mk(OP_STEP, 0, 0, 0, 0, 0, ONE / 4));
        drain();
        write_reg(CFG_OBST_COUNT, 0);
        send_word(mk(OP_STEP, 0, 0, 0, 0, 0, ONE / 4));
        drain();
        write_reg(CFG_BODY_COUNT, 0);
        write_reg(CFG_OBST_COUNT, 1);
        send_word(mk(OP_STEP, 0, 0, 0, 0, 0, ONE / 4));
        drain();
    endtask

    task automatic test_full_tables;
        for (int j = 0; j < OBSTACLE_SPHERES; j++)
            send_word(mk(OP_LOAD_OBST, j, rnd_q(40), rnd_q(40), rnd_q(40), $urandom_range(0, 2 * ONE), 0));
        drain();
        write_reg(CFG_BODY_COUNT, 31);
        write_reg(CFG_OBST_COUNT, 511);
        send_word(mk(OP_SET_POS, 0, rnd_q(8), rnd_q(8), rnd_q(8), 0, 0));
        send_word(mk(OP_STEP, 0, rnd_q(4), rnd_q(4), rnd_q(4), 0, ONE / 8));
        drain();
        write_reg(CFG_BODY_COUNT, 16);
        write_reg(CFG_OBST_COUNT, 256);
        send_word(mk(OP_STEP, 0, rnd_q(4), rnd_q(4), rnd_q(4), 0, ONE / 8));
        drain();
    endtask

    task automatic test_random;
        cmd_t c;
        int sel;
        for (int n = 0; n < 100; n++) begin
            if (n % 20 == 0) begin
                drain();
                write_reg(CFG_BODY_COUNT, 24'($urandom_range(0, 31)));
                write_reg(CFG_OBST_COUNT, ($urandom_range(0, 9) == 0)
                                          ? 24'($urandom_range(0, 511))
                                          : 24'($urandom_range(0, 12)));
                sel = $urandom_range(0, 3);
                write_reg(CFG_TIME_MULT, sel == 0 ? 24'hffffff : sel == 1 ? 24'd0 :
                                         sel == 2 ? 24'(ONE) : 24'($urandom));
            end
            if ($urandom_range(0, 9) == 0) begin
                c.op = op_t'($urandom_range(0, 3));
                c.idx = 8'($urandom);
                c.x = $urandom;
                c.y = $urandom;
                c.z = $urandom;
                c.rad = 31'($urandom);
                c.dt = 16'($urandom);
            end else begin
                sel = $urandom_range(0, 19);
                c.op = sel < 10 ? OP_STEP : sel < 13 ? OP_SET_POS : sel < 17 ? OP_LOAD_OBST
                                                                             : OP_LOAD_BODY;
                c.idx = (c.op == OP_LOAD_BODY) ? 8'($urandom_range(0, 20))
                                               : 8'($urandom_range(0, 15));
                c.x = rnd_q(c.op == OP_STEP ? 8 : 16);
                c.y = rnd_q(c.op == OP_STEP ? 8 : 16);
                c.z = rnd_q(c.op == OP_STEP ? 8 : 16);
                c.rad = 31'($urandom_range(0, 2 * ONE));
                c.dt = 16'($urandom);
            end
            send_word(c);
        end
        drain();
    endtask

    initial begin
        pos = '{0, 0, 0};
        vel = '{0, 0, 0};
        body_cnt = 1;
        obst_cnt = 0;
        tmult = 24'(ONE);
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_loads();
        test_extremes();
        test_collision();
        test_full_tables();
        test_random();
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_pos.size() == 0)
            $display("sphere_collision_motion_step_unit: match");
        else
            $display("sphere_collision_motion_step_unit: mismatch");
        $finish;
    end

    initial begin
        #20000000;
        $display("sphere_collision_motion_step_unit: mismatch");
        $finish;
    end

endmodule
